@@ sv/cct_pkg.sv @@
package cct_pkg;

    typedef logic [7:0] byte_t;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_NAME   = 3'd1;
    localparam logic [2:0] ST_EMPTY_NAME = 3'd2;
    localparam logic [2:0] ST_BAD_PARAM  = 3'd3;
    localparam logic [2:0] ST_EMPTY_PARAM = 3'd4;
    localparam logic [2:0] ST_TOO_LONG   = 3'd5;

    // call types
    localparam logic [3:0] CT_ERROR = 4'd0;
    localparam logic [3:0] CT_LF    = 4'd1;
    localparam logic [3:0] CT_HELP  = 4'd2;
    localparam logic [3:0] CT_LV    = 4'd3;
    localparam logic [3:0] CT_FUNC  = 4'd4;
    localparam logic [3:0] CT_GET   = 4'd5;
    localparam logic [3:0] CT_SET   = 4'd6;
    localparam logic [3:0] CT_READ  = 4'd7;
    localparam logic [3:0] CT_WRITE = 4'd8;

    // special characters
    localparam byte_t CH_ZERO     = 8'h00;
    localparam byte_t CH_OPEN     = 8'h28;
    localparam byte_t CH_CLOSE    = 8'h29;
    localparam byte_t CH_COMMA    = 8'h2c;
    localparam byte_t CH_QUOTE    = 8'h22;
    localparam byte_t CH_UNDER    = 8'h5f;
    localparam byte_t CH_PRINT_LO = 8'd33;
    localparam byte_t CH_PRINT_HI = 8'd126;

    // keyword table, in match priority order
    localparam int NUM_KW = 7;
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5, 3'd4};
    localparam logic [3:0] KW_TYPE [NUM_KW] = '{CT_LF, CT_LV, CT_GET, CT_SET, CT_READ,
                                                 CT_WRITE, CT_HELP};
    localparam byte_t KW_TEXT [NUM_KW][8] = '{
        '{8'h6c, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6c, 8'h76, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h67, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h72, 8'h65, 8'h61, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h77, 8'h72, 8'h69, 8'h74, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h68, 8'h65, 8'h6c, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [5:0] COUNT_MAX = 6'd63;

    typedef struct packed {
        logic is_zero;
        logic is_name;
        logic is_print;
        logic is_open;
        logic is_close;
        logic is_comma;
        logic is_quote;
    } char_class_t;

    // packed first field in the high bits
    typedef struct packed {
        logic        pad;
        logic [3:0]  string_mask;
        logic [27:0] param_ends;
        logic [27:0] param_starts;
        logic [5:0]  param_count;
        logic [5:0]  name_end;
        logic [3:0]  call_type;
        logic [2:0]  status;
    } result_t;

endpackage

@@ sv/command_call_tokenizer.sv @@
// A summary appears on m_tvalid once the byte that decides it has passed through the
// input register and then the result register.
// Throughput: one byte per cycle; the input register and the result register each
// advance whenever the stage after them is empty or being drained.
// Reset (synchronous, aresetn low) empties both registers and returns the line state
// to the start of a name; a zero byte does the same for the line state at run time.
module command_call_tokenizer #(
    parameter int MAX_PARAMS  = 4,
    parameter int LINE_LENGTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // [2:0] status, [6:3] call_type, [12:7] name_end,
                                   // [18:13] param_count, [46:19] param_starts,
                                   // [74:47] param_ends, [78:75] string_mask, [79] zero
);

    localparam int POS_W = $clog2(LINE_LENGTH);
    localparam int EW    = (POS_W + 1 > 7) ? POS_W + 1 : 7;
    localparam int NSLOT = (MAX_PARAMS < 4) ? MAX_PARAMS : 4;

    typedef enum logic [1:0] {
        PH_NAME,
        PH_PARAM,
        PH_SKIP
    } phase_t;

    // input register
    logic           in_valid_reg;
    cct_pkg::byte_t in_byte_reg;

    // line state
    phase_t                         phase_reg, phase_next;
    logic [POS_W-1:0]               position_reg, position_next;
    logic [POS_W-1:0]               token_start_reg, token_start_next;
    logic [POS_W-1:0]               name_last_reg, name_last_next;
    logic                           prev_quote_reg, prev_quote_next;
    logic [5:0]                     count_reg, count_next;
    logic [MAX_PARAMS-1:0]          flags_reg, flags_next;
    logic [cct_pkg::NUM_KW-1:0]     kw_reg, kw_next;
    logic [6:0]                     start_reg [MAX_PARAMS];
    logic [6:0]                     start_next [MAX_PARAMS];
    logic [6:0]                     end_reg [MAX_PARAMS];
    logic [6:0]                     end_next [MAX_PARAMS];

    // result register
    logic              out_valid_reg;
    cct_pkg::result_t  out_data_reg;

    cct_pkg::char_class_t cls;
    cct_pkg::result_t     res;
    logic                 res_valid;
    logic                 advance;
    logic                 do_err, do_ok, do_record, do_step, do_clear;
    logic [2:0]           err_code;
    logic [3:0]           call_type;
    logic [27:0]          st_packed, en_packed;
    logic [6:0]           rec_start, rec_end;
    logic [EW-1:0]        pos_ext;

    cct_char_class u_class (
        .char_code (in_byte_reg),
        .cls       (cls)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pos_ext  = EW'(position_reg);

    // decide what the byte does
    always_comb begin
        do_err    = 1'b0;
        do_ok     = 1'b0;
        do_record = 1'b0;
        do_step   = 1'b0;
        do_clear  = 1'b0;
        err_code  = cct_pkg::ST_OK;
        unique case (phase_reg)
            PH_SKIP: begin
                do_clear = cls.is_zero;
            end
            PH_NAME, PH_PARAM: begin
                priority if (!cls.is_zero && position_reg >= POS_W'(LINE_LENGTH - 1)) begin
                    do_err   = 1'b1;
                    err_code = cct_pkg::ST_TOO_LONG;
                end else if (phase_reg == PH_NAME) begin
                    priority if (cls.is_open) begin
                        if (position_reg == '0) begin
                            do_err   = 1'b1;
                            err_code = cct_pkg::ST_EMPTY_NAME;
                        end else begin
                            do_step = 1'b1;
                        end
                    end else if (cls.is_name) begin
                        do_step = 1'b1;
                    end else begin
                        do_err   = 1'b1;
                        err_code = cct_pkg::ST_BAD_NAME;
                    end
                end else begin
                    priority if (!cls.is_print) begin
                        do_err   = 1'b1;
                        err_code = cct_pkg::ST_BAD_PARAM;
                    end else if (cls.is_close &&
                                 pos_ext == EW'(name_last_reg) + EW'(2)) begin
                        do_ok = 1'b1;
                    end else if (cls.is_comma || cls.is_close) begin
                        if (position_reg == token_start_reg) begin
                            do_err   = 1'b1;
                            err_code = cct_pkg::ST_EMPTY_PARAM;
                        end else begin
                            do_record = 1'b1;
                            do_ok     = cls.is_close;
                            do_step   = cls.is_comma;
                        end
                    end else begin
                        do_step = 1'b1;
                    end
                end
                if (do_err && cls.is_zero) begin
                    do_clear = 1'b1;
                end
            end
            default: begin
                do_clear = 1'b1;
            end
        endcase
    end

    assign rec_start = prev_quote_reg ? 7'(EW'(token_start_reg) + EW'(1))
                                      : 7'(token_start_reg);
    assign rec_end   = prev_quote_reg ? 7'(pos_ext - EW'(2)) : 7'(pos_ext - EW'(1));

    // next line state
    always_comb begin
        phase_next       = phase_reg;
        position_next    = position_reg;
        token_start_next = token_start_reg;
        name_last_next   = name_last_reg;
        prev_quote_next  = prev_quote_reg;
        count_next       = count_reg;
        flags_next       = flags_reg;
        kw_next          = kw_reg;
        for (int i = 0; i < MAX_PARAMS; i++) begin
            start_next[i] = start_reg[i];
            end_next[i]   = end_reg[i];
        end

        if (phase_reg == PH_NAME && do_step) begin
            for (int k = 0; k < cct_pkg::NUM_KW; k++) begin
                if (cls.is_open) begin
                    if (position_reg != POS_W'(cct_pkg::KW_LEN[k])) begin
                        kw_next[k] = 1'b0;
                    end
                end else if (!(position_reg < POS_W'(cct_pkg::KW_LEN[k]) &&
                               cct_pkg::KW_TEXT[k][position_reg[2:0]] == in_byte_reg)) begin
                    kw_next[k] = 1'b0;
                end
            end
            if (cls.is_open) begin
                name_last_next   = position_reg - POS_W'(1);
                token_start_next = position_reg + POS_W'(1);
                phase_next       = PH_PARAM;
            end
        end

        if (do_record) begin
            for (int i = 0; i < MAX_PARAMS; i++) begin
                if (count_reg == 6'(i)) begin
                    start_next[i] = rec_start;
                    end_next[i]   = rec_end;
                    flags_next[i] = prev_quote_reg;
                end
            end
            if (count_reg < cct_pkg::COUNT_MAX) begin
                count_next = count_reg + 6'd1;
            end
        end

        if (phase_reg == PH_PARAM && do_step && cls.is_comma) begin
            token_start_next = position_reg + POS_W'(1);
        end

        if (do_step) begin
            prev_quote_next = cls.is_quote;
            position_next   = position_reg + POS_W'(1);
        end

        if (do_ok || do_err) begin
            phase_next = PH_SKIP;
        end

        if (do_clear) begin
            phase_next       = PH_NAME;
            position_next    = '0;
            token_start_next = '0;
            name_last_next   = '0;
            prev_quote_next  = 1'b0;
            count_next       = '0;
            flags_next       = '0;
            kw_next          = '1;
        end
    end

    // first matching keyword wins
    always_comb begin
        call_type = cct_pkg::CT_FUNC;
        for (int k = cct_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (kw_reg[k]) begin
                call_type = cct_pkg::KW_TYPE[k];
            end
        end
    end

    // pack the slots that hold a recorded parameter
    for (genvar g = 0; g < 4; g++) begin : g_slot
        if (g < NSLOT) begin : g_used
            assign st_packed[7*g +: 7] = (count_next > 6'(g)) ? start_next[g] : 7'd0;
            assign en_packed[7*g +: 7] = (count_next > 6'(g)) ? end_next[g] : 7'd0;
        end else begin : g_unused
            assign st_packed[7*g +: 7] = 7'd0;
            assign en_packed[7*g +: 7] = 7'd0;
        end
    end

    always_comb begin
        res       = '0;
        res_valid = do_ok || do_err;
        if (do_err) begin
            res.status = err_code;
        end else if (do_ok) begin
            res.status       = cct_pkg::ST_OK;
            res.call_type    = call_type;
            res.name_end     = 6'(name_last_reg);
            res.param_count  = count_next;
            res.param_starts = st_packed;
            res.param_ends   = en_packed;
            res.string_mask  = 4'(flags_next[NSLOT-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_NAME;
            position_reg    <= '0;
            token_start_reg <= '0;
            name_last_reg   <= '0;
            prev_quote_reg  <= 1'b0;
            count_reg       <= '0;
            flags_reg       <= '0;
            kw_reg          <= '1;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg   <= res_valid;
                phase_reg       <= phase_next;
                position_reg    <= position_next;
                token_start_reg <= token_start_next;
                name_last_reg   <= name_last_next;
                prev_quote_reg  <= prev_quote_next;
                count_reg       <= count_next;
                flags_reg       <= flags_next;
                kw_reg          <= kw_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            for (int i = 0; i < MAX_PARAMS; i++) begin
                start_reg[i] <= start_next[i];
                end_reg[i]   <= end_next[i];
            end
            if (res_valid) begin
                out_data_reg <= res;
            end
        end
    end

    a_new_result_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a byte in the input register");

    a_param_after_name: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PARAM |-> EW'(position_reg) >= EW'(name_last_reg) + EW'(2))
        else $error("parameter phase entered before the name ended");

    a_name_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_NAME |-> (count_reg == '0 && flags_reg == '0))
        else $error("parameter state left over while reading a name");

    a_position_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg <= POS_W'(LINE_LENGTH - 1))
        else $error("position ran past the line length");

    a_result_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result dropped or changed");

endmodule

@@ sv/cct_char_class.sv @@
module cct_char_class (
    input  cct_pkg::byte_t       char_code,
    output cct_pkg::char_class_t cls
);

    always_comb begin
        cls.is_zero  = (char_code == cct_pkg::CH_ZERO);
        cls.is_name  = (char_code >= 8'h61 && char_code <= 8'h7a) ||
                       (char_code >= 8'h41 && char_code <= 8'h5a) ||
                       (char_code >= 8'h30 && char_code <= 8'h39) ||
                       (char_code == cct_pkg::CH_UNDER);
        cls.is_print = (char_code >= cct_pkg::CH_PRINT_LO) &&
                       (char_code <= cct_pkg::CH_PRINT_HI);
        cls.is_open  = (char_code == cct_pkg::CH_OPEN);
        cls.is_close = (char_code == cct_pkg::CH_CLOSE);
        cls.is_comma = (char_code == cct_pkg::CH_COMMA);
        cls.is_quote = (char_code == cct_pkg::CH_QUOTE);
    end

endmodule
